/* hw/rtl/ytv_pkg.sv */
`timescale 1ns / 1ps
package ytv_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW   = 5;

  localparam logic [2:0] RegPropGain   = 3'd0;
  localparam logic [2:0] RegIntGain    = 3'd1;
  localparam logic [2:0] RegMaxDiff    = 3'd2;
  localparam logic [2:0] RegRearDist   = 3'd3;
  localparam logic [2:0] RegFrontDist  = 3'd4;
  localparam logic [2:0] RegMass       = 3'd5;
  localparam logic [2:0] RegFrontStiff = 3'd6;
  localparam logic [2:0] RegRearStiff  = 3'd7;

  // Multiplier operand selects.
  typedef enum logic [3:0] {
    MselVel,     // motor * velocity coefficient
    MselLrM,     // lr * m
    MselCyfWb,   // cyf * wb
    MselLfM,     // lf * m
    MselCyrWb,   // cyr * wb
    MselVv,      // vel * vel
    MselKuVv,    // ku * vv
    MselDesired, // quotient * delta
    MselErrDt,   // err * dt
    MselPErr,    // kp * err
    MselIInt     // ki * integral
  } msel_e;

  // Divider operand selects.
  typedef enum logic [1:0] {
    DselKu1,
    DselKu2,
    DselVel
  } dsel_e;

  // Register-update steps that are not products or quotients.
  typedef enum logic [3:0] {
    OpNone,
    OpWb,
    OpKu,
    OpDen,
    OpErr,
    OpInteg,
    OpCtl,
    OpOut,
    OpIdle
  } op_e;

  typedef struct packed {
    logic  load;
    logic  mul_go;
    msel_e msel;
    logic  div_go;
    dsel_e dsel;
    op_e   op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic slow;
  } sts_t;

  typedef enum logic [4:0] {
    StIdle, StVel, StVelW, StCheck, StLrM, StLrMW, StCyfWb, StCyfWbW, StDiv1, StDiv1W,
    StLfM, StLfMW, StCyrWb, StCyrWbW, StDiv2, StDiv2W, StKu, StVv, StVvW, StKuVv,
    StKuVvW, StDen, StDiv3, StDiv3W, StDes, StDesW, StErr, StErrDt, StErrDtW,
    StPErr, StPErrW, StIInt
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* hw/rtl/ytv_mul.sv */
`timescale 1ns / 1ps
module ytv_mul #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic signed [32:0]  a_i,
  input  logic signed [32:0]  b_i,
  input  logic                coef_i,
  output logic                done_o,
  output logic signed [31:0]  p_o
);
  import ytv_pkg::*;

  // Two 33x17 partial products, accumulated in turn, then flooring and saturation.
  logic signed [32:0] a_q, b_q;
  logic               coef_q;
  logic [1:0]         step_q, step_d;
  logic signed [65:0] acc_q, acc_d;
  logic signed [31:0] p_q, p_d;
  logic signed [65:0] shifted;

  always_comb begin
    step_d = step_q;
    acc_d  = acc_q;
    p_d    = p_q;
    shifted = coef_q ? (acc_q >>> 32) : (acc_q >>> FracBits);
    case (step_q)
      2'd0: if (go_i) step_d = 2'd1;
      2'd1: begin
        acc_d  = 66'(a_q * $signed({1'b0, b_q[15:0]}));
        step_d = 2'd2;
      end
      2'd2: begin
        acc_d  = acc_q + (66'(a_q * $signed(b_q[32:16])) <<< 16);
        step_d = 2'd3;
      end
      2'd3: begin
        p_d    = sat32(shifted);
        step_d = 2'd0;
      end
      default: step_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (go_i && step_q == 2'd0) begin
      a_q    <= a_i;
      b_q    <= b_i;
      coef_q <= coef_i;
    end
    acc_q <= acc_d;
    p_q   <= p_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_o <= 1'b0;
    end else begin
      step_q <= step_d;
      done_o <= (step_q == 2'd3);
    end
  end

  assign p_o = p_q;
endmodule

/* hw/rtl/ytv_div.sv */
`timescale 1ns / 1ps
module ytv_div #(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);
  import ytv_pkg::*;

  // Restoring division, one quotient bit a cycle over a 48-bit magnitude.
  localparam int unsigned NW = 32 + FracBits;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, quo_q;
  logic [32:0]   rem_q, den_q;
  logic          neg_q, zero_q, nz_q, busy_q;
  logic [CW-1:0] cnt_q;
  logic signed [31:0] q_q;
  logic [33:0]   trial;
  logic signed [NW+1:0] sq;

  assign trial = {rem_q, num_q[NW-1]} - {1'b0, den_q};
  assign sq    = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  always_ff @(posedge clk_i) begin
    if (go_i && !busy_q) begin
      num_q  <= NW'(a_i[31] ? -{{FracBits{1'b0}}, a_i} << FracBits
                            : {{FracBits{1'b0}}, a_i} << FracBits);
      den_q  <= b_i[31] ? 33'(-{1'b1, b_i}) : {1'b0, b_i};
      neg_q  <= a_i[31] ^ b_i[31];
      zero_q <= (b_i == '0);
      nz_q   <= (a_i != '0);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (!trial[33]) begin
        rem_q <= trial[32:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], num_q[NW-1]};
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
    if (busy_q && cnt_q == CW'(NW)) begin
      if (zero_q)
        q_q <= !nz_q ? 32'sd0 : (neg_q ? 32'sh80000000 : 32'sh7fffffff);
      else
        q_q <= sat32(66'(sq));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (go_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NW)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign q_o = q_q;
endmodule

/* hw/rtl/ytv_datapath.sv */
`timescale 1ns / 1ps
module ytv_datapath #(
  parameter int unsigned FracBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ytv_pkg::cmd_t        cmd_i,
  output ytv_pkg::sts_t        sts_o,
  input  logic [127:0]         in_data_i,
  input  logic [30:0]          regs_i [8],
  output logic [103:0]         out_data_o
);
  import ytv_pkg::*;

  localparam logic signed [32:0] VelCoef = 33'sd44976792;
  localparam int Eps = (1 << FracBits) / 10000;

  logic signed [31:0] motor_q, delta_q, meas_q, integ_q;
  logic [30:0]        dt_q;
  logic signed [31:0] vel_q, wb_q, t1_q, t2_q, q1_q, ku_q, vv_q, den_q, des_q, err_q;
  logic signed [31:0] perr_q, ctl_q, ld_q, rd_q;
  logic               act_q;

  logic signed [32:0] ma, mb;
  logic signed [31:0] mp, dq, da, db;
  logic               md, dd;
  logic signed [32:0] maxd;
  logic signed [31:0] half, ctl_c;

  assign maxd = {2'b00, regs_i[RegMaxDiff]};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.msel)
      MselVel:     begin ma = 33'(motor_q); mb = VelCoef; end
      MselLrM:     begin ma = {2'b0, regs_i[RegRearDist]};   mb = {2'b0, regs_i[RegMass]}; end
      MselCyfWb:   begin ma = {2'b0, regs_i[RegFrontStiff]}; mb = 33'(wb_q); end
      MselLfM:     begin ma = {2'b0, regs_i[RegFrontDist]};  mb = {2'b0, regs_i[RegMass]}; end
      MselCyrWb:   begin ma = {2'b0, regs_i[RegRearStiff]};  mb = 33'(wb_q); end
      MselVv:      begin ma = 33'(vel_q); mb = 33'(vel_q); end
      MselKuVv:    begin ma = 33'(ku_q);  mb = 33'(vv_q); end
      MselDesired: begin ma = 33'(des_q); mb = 33'(delta_q); end
      MselErrDt:   begin ma = 33'(err_q); mb = {2'b0, dt_q}; end
      MselPErr:    begin ma = {2'b0, regs_i[RegPropGain]}; mb = 33'(err_q); end
      MselIInt:    begin ma = {2'b0, regs_i[RegIntGain]};  mb = 33'(integ_q); end
      default:     ;
    endcase
    da = t1_q;
    db = t2_q;
    case (cmd_i.dsel)
      DselVel: begin da = vel_q; db = den_q; end
      default: ;
    endcase
  end

  ytv_mul #(.FracBits(FracBits)) u_mul (
    .clk_i, .rst_ni, .go_i(cmd_i.mul_go), .a_i(ma), .b_i(mb),
    .coef_i(cmd_i.msel == MselVel), .done_o(md), .p_o(mp)
  );

  ytv_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .go_i(cmd_i.div_go), .a_i(da), .b_i(db), .done_o(dd), .q_o(dq)
  );

  always_comb begin
    ctl_c = sat32(66'(perr_q) + 66'(mp));
    if (66'(ctl_c) > 66'(maxd)) ctl_c = maxd[31:0];
    else if (66'(ctl_c) < -66'(maxd)) ctl_c = 32'(-maxd);
    half = ctl_q >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      motor_q <= in_data_i[31:0];
      delta_q <= in_data_i[63:32];
      meas_q  <= in_data_i[95:64];
      dt_q    <= in_data_i[126:96];
    end
    if (md) begin
      case (cmd_i.msel)
        MselVel:     vel_q  <= mp;
        MselLrM:     t1_q   <= mp;
        MselCyfWb:   t2_q   <= mp;
        MselLfM:     t1_q   <= mp;
        MselCyrWb:   t2_q   <= mp;
        MselVv:      vv_q   <= mp;
        MselKuVv:    den_q  <= sat32(66'(wb_q) + 66'(mp));
        MselDesired: des_q  <= mp;
        MselErrDt:   t1_q   <= mp;
        MselPErr:    perr_q <= mp;
        MselIInt:    ctl_q  <= ctl_c;
        default: ;
      endcase
    end
    if (dd) begin
      case (cmd_i.dsel)
        DselKu1: q1_q  <= dq;
        DselKu2: ku_q  <= sat32(66'(q1_q) - 66'(dq));
        DselVel: des_q <= dq;
        default: ;
      endcase
    end
    case (cmd_i.op)
      OpWb:  wb_q <= sat32(66'({1'b0, regs_i[RegFrontDist]}) + 66'({1'b0, regs_i[RegRearDist]}));
      OpDen: if (den_q <= 32'(Eps) && den_q >= -32'(Eps)) des_q <= '0;
      OpErr: err_q <= sat32(66'(des_q) - 66'(meas_q));
      OpOut: begin
        ld_q  <= sat32(66'(motor_q) - 66'(half));
        rd_q  <= sat32(66'(motor_q) + 66'(half));
        act_q <= 1'b1;
      end
      OpIdle: begin
        ld_q  <= motor_q;
        rd_q  <= motor_q;
        ctl_q <= '0;
        act_q <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) integ_q <= '0;
    else if (cmd_i.op == OpInteg) integ_q <= sat32(66'(integ_q) + 66'(t1_q));
  end

  assign sts_o.mul_done = md;
  assign sts_o.div_done = dd;
  assign sts_o.slow     = (vel_q <= 32'(5 << FracBits));
  assign out_data_o = {7'd0, act_q, ctl_q, rd_q, ld_q};
endmodule

/* hw/rtl/ytv_ctrl.sv */
`timescale 1ns / 1ps
module ytv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  input  ytv_pkg::sts_t sts_i,
  output ytv_pkg::cmd_t cmd_o
);
  import ytv_pkg::*;

  state_e state_q, state_d;
  logic   busy_q, busy_d, ov_q, ov_d;

  // Issue a unit start and wait state pair.
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    ov_d    = ov_q;
    cmd_o   = '{load: 1'b0, mul_go: 1'b0, msel: MselVel, div_go: 1'b0,
                dsel: DselKu1, op: OpNone};
    if (ov_q && m_tready_i) ov_d = 1'b0;
    s_tready_o = (state_q == StIdle) && !ov_q;
    case (state_q)
      StIdle: if (s_tvalid_i && s_tready_o) begin
        cmd_o.load = 1'b1; busy_d = 1'b1; state_d = StVel;
      end
      StVel:    begin cmd_o.mul_go = 1'b1; state_d = StVelW; end
      StVelW:   if (sts_i.mul_done) state_d = StCheck;
      StCheck:  begin
        if (sts_i.slow) begin
          cmd_o.op = OpIdle; ov_d = 1'b1; busy_d = 1'b0; state_d = StIdle;
        end else begin
          cmd_o.op = OpWb; state_d = StLrM;
        end
      end
      StLrM:    begin cmd_o.msel = MselLrM; cmd_o.mul_go = 1'b1; state_d = StLrMW; end
      StLrMW:   begin cmd_o.msel = MselLrM; if (sts_i.mul_done) state_d = StCyfWb; end
      StCyfWb:  begin cmd_o.msel = MselCyfWb; cmd_o.mul_go = 1'b1; state_d = StCyfWbW; end
      StCyfWbW: begin cmd_o.msel = MselCyfWb; if (sts_i.mul_done) state_d = StDiv1; end
      StDiv1:   begin cmd_o.div_go = 1'b1; state_d = StDiv1W; end
      StDiv1W:  if (sts_i.div_done) state_d = StLfM;
      StLfM:    begin cmd_o.msel = MselLfM; cmd_o.mul_go = 1'b1; state_d = StLfMW; end
      StLfMW:   begin cmd_o.msel = MselLfM; if (sts_i.mul_done) state_d = StCyrWb; end
      StCyrWb:  begin cmd_o.msel = MselCyrWb; cmd_o.mul_go = 1'b1; state_d = StCyrWbW; end
      StCyrWbW: begin cmd_o.msel = MselCyrWb; if (sts_i.mul_done) state_d = StDiv2; end
      StDiv2:   begin cmd_o.dsel = DselKu2; cmd_o.div_go = 1'b1; state_d = StDiv2W; end
      StDiv2W:  begin cmd_o.dsel = DselKu2; if (sts_i.div_done) state_d = StKu; end
      StKu:     state_d = StVv;
      StVv:     begin cmd_o.msel = MselVv; cmd_o.mul_go = 1'b1; state_d = StVvW; end
      StVvW:    begin cmd_o.msel = MselVv; if (sts_i.mul_done) state_d = StKuVv; end
      StKuVv:   begin cmd_o.msel = MselKuVv; cmd_o.mul_go = 1'b1; state_d = StKuVvW; end
      StKuVvW:  begin cmd_o.msel = MselKuVv; if (sts_i.mul_done) state_d = StDiv3; end
      StDiv3:   begin cmd_o.dsel = DselVel; cmd_o.div_go = 1'b1; state_d = StDiv3W; end
      StDiv3W:  begin cmd_o.dsel = DselVel; if (sts_i.div_done) state_d = StDes; end
      StDes:    begin cmd_o.msel = MselDesired; cmd_o.mul_go = 1'b1; state_d = StDesW; end
      StDesW:   begin cmd_o.msel = MselDesired; if (sts_i.mul_done) state_d = StDen; end
      // The small-denominator case overrides the product with zero.
      StDen:    begin cmd_o.op = OpDen; state_d = StErr; end
      StErr:    begin cmd_o.op = OpErr; state_d = StErrDt; end
      StErrDt:  begin cmd_o.msel = MselErrDt; cmd_o.mul_go = 1'b1; state_d = StErrDtW; end
      StErrDtW: begin
        cmd_o.msel = MselErrDt;
        if (sts_i.mul_done) state_d = StPErr;
      end
      StPErr:   begin cmd_o.op = OpInteg; cmd_o.msel = MselPErr; cmd_o.mul_go = 1'b1;
                      state_d = StPErrW; end
      StPErrW:  begin cmd_o.msel = MselPErr; if (sts_i.mul_done) state_d = StIInt; end
      StIInt:   begin
        cmd_o.msel = MselIInt;
        if (!busy_q) begin
          cmd_o.op = OpOut; ov_d = 1'b1; state_d = StIdle;
        end else if (sts_i.mul_done) begin
          busy_d = 1'b0;
        end else if (ov_q == 1'b0 && busy_q) begin
          cmd_o.mul_go = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      ov_q    <= ov_d;
    end
  end

  assign m_tvalid_o = ov_q;
endmodule

/* hw/rtl/yaw_rate_torque_vectoring_pi.sv */
`timescale 1ns / 1ps
// At or below the speed threshold, a request returns after the velocity product and check.
// Above it, three serial quotients, nine multiplier passes and a final pass follow.
// One request is in flight at a time.
// A new request is accepted only after the result handoff completes.
// Reset is asynchronous and active low; it clears the control state, the
// error integral and the configuration registers to their reset values.
module yaw_rate_torque_vectoring_pi #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid,
  output logic          s_tready,
  // motor_speed[31:0], steer_angle[63:32], measured_yaw_rate[95:64],
  // tick_period[126:96], zero fill
  input  logic [127:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // left_torque[31:0], right_torque[63:32], torque_diff[95:64],
  // vectoring_active[96], zero fill
  output logic [103:0]  m_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [ytv_pkg::AddrW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ytv_pkg::*;

  logic [30:0] regs_q [NumRegs];
  cmd_t cmd;
  sts_t sts;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign prdata = {1'b0, regs_q[ridx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[RegPropGain]   <= 31'd65536;
      regs_q[RegIntGain]    <= 31'd0;
      regs_q[RegMaxDiff]    <= 31'd262144;
      regs_q[RegRearDist]   <= 31'd65536;
      regs_q[RegFrontDist]  <= 31'd65536;
      regs_q[RegMass]       <= 31'd20971520;
      regs_q[RegFrontStiff] <= 31'd29097984;
      regs_q[RegRearStiff]  <= 31'd29097984;
    end else if (psel && penable && pwrite) begin
      regs_q[ridx] <= pwdata[30:0];
    end
  end

  ytv_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .sts_i(sts), .cmd_o(cmd)
  );

  ytv_datapath #(.FracBits(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_data_i(s_tdata),
    .regs_i(regs_q), .out_data_o(m_tdata)
  );
endmodule

/* hw/rtl/ytv_checker.sv */
`timescale 1ns / 1ps
module ytv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata
);
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second request accepted");
  a_idle_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tdata[96]) |-> (m_tdata[95:64] == '0))
    else $error("nonzero difference while inactive");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped");
endmodule

bind yaw_rate_torque_vectoring_pi ytv_checker u_chk (
  .clk_i, .rst_ni, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
